/* hdl/anem_pkg.sv */
package anem_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] RegDebounce = 2'd0;
   localparam logic [1:0] RegWindow   = 2'd1;
   localparam logic [1:0] RegScale    = 2'd2;

   // Register reset values
   localparam logic [15:0] DebounceReset = 16'd15;
   localparam logic [15:0] WindowReset   = 16'd1000;
   localparam logic [15:0] ScaleReset    = 16'd382;  // about 1.492 in Q8.8

   localparam int CfgWidth    = 16;
   localparam int SampleWidth = 12;
   localparam int ClickWidth  = 8;
   localparam int SpeedWidth  = 24;
   localparam int DirWidth    = 10;
   localparam int DirSteps    = 16;

   // Direction for a reading below the lowest vane threshold
   localparam logic signed [DirWidth-1:0] DirUnknown = -10'sd1;

   // Vane thresholds, descending, and the direction for each band
   localparam logic [SampleWidth-1:0] DirLimit [DirSteps] = '{
      12'd3684, 12'd3287, 12'd3100, 12'd2812, 12'd2508, 12'd2350, 12'd2230, 12'd1594,
      12'd1377, 12'd931,  12'd800,  12'd547,  12'd345,  12'd209,  12'd178,  12'd107
   };
   localparam logic signed [DirWidth-1:0] DirDegrees [DirSteps] = '{
      10'sd270, 10'sd315, 10'sd300, 10'sd360, 10'sd340, 10'sd225, 10'sd250, 10'sd45,
      10'sd30,  10'sd180, 10'sd210, 10'sd135, 10'sd160, 10'sd90,  10'sd70,  10'sd120
   };

   // One tick as taken from the input channel
   typedef struct packed {
      logic                   wind_edge;
      logic                   dir_valid;
      logic [SampleWidth-1:0] dir_sample;
   } tick_type;

   // Window summary handed from the tick stage to the gust stage
   typedef struct packed {
      logic [ClickWidth-1:0]      click_count;
      logic signed [DirWidth-1:0] last_heading;
   } window_type;

   // Configuration values
   typedef struct packed {
      logic [CfgWidth-1:0] debounce_ticks;
      logic [CfgWidth-1:0] window_ticks;
      logic [CfgWidth-1:0] speed_scale;
   } cfg_type;

   // Map a vane reading to degrees; first threshold met wins
   function automatic logic signed [DirWidth-1:0] decode_direction(
      input logic [SampleWidth-1:0] sample
   );
      logic signed [DirWidth-1:0] dir;
      dir = DirUnknown;
      for (int i = DirSteps - 1; i >= 0; i--) begin
         if (sample >= DirLimit[i]) begin
            dir = DirDegrees[i];
         end
      end
      return dir;
   endfunction

endpackage

/* hdl/anem_tick.sv */
module anem_tick (
   input  logic                  clock,
   input  logic                  reset,
   input  anem_pkg::cfg_type     cfg,
   input  logic                  tick_fire,
   input  anem_pkg::tick_type    tick,
   output logic                  win_end,
   output anem_pkg::window_type  win
);

   localparam int TW = anem_pkg::CfgWidth;
   localparam int CW = anem_pkg::ClickWidth;

   logic [TW-1:0] since_ff, since_in, since_inc;
   logic [CW-1:0] clicks_ff, clicks_in, clicks_upd;
   logic [TW-1:0] pos_ff, pos_in, span;
   logic signed [anem_pkg::DirWidth-1:0] dir_ff, dir_upd;
   logic          counted;
   logic [TW:0]   pos_next;

   // Debounce the anemometer edge and count clicks
   always_comb begin
      since_inc  = (since_ff != '1) ? since_ff + 1'b1 : since_ff;
      counted    = tick.wind_edge && (since_inc > cfg.debounce_ticks);
      since_in   = counted ? '0 : since_inc;
      clicks_upd = (counted && clicks_ff != '1) ? clicks_ff + 1'b1 : clicks_ff;
   end

   // Decode a fresh vane reading
   assign dir_upd = tick.dir_valid ? anem_pkg::decode_direction(tick.dir_sample) : dir_ff;

   // Advance the window; a zero length acts as one
   always_comb begin
      span      = (cfg.window_ticks == '0) ? TW'(1) : cfg.window_ticks;
      pos_next  = {1'b0, pos_ff} + (TW+1)'(1);
      win_end   = pos_next >= {1'b0, span};
      pos_in    = win_end ? '0 : pos_next[TW-1:0];
      clicks_in = win_end ? '0 : clicks_upd;
   end

   assign win.click_count  = clicks_upd;
   assign win.last_heading = dir_upd;

   // Hold state between ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff  <= '1;
         clicks_ff <= '0;
         pos_ff    <= '0;
         dir_ff    <= anem_pkg::DirUnknown;
      end else if (tick_fire) begin
         since_ff  <= since_in;
         clicks_ff <= clicks_in;
         pos_ff    <= pos_in;
         dir_ff    <= dir_upd;
      end
   end

endmodule

/* hdl/anem_gust.sv */
module anem_gust (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [anem_pkg::CfgWidth-1:0] speed_scale,
   input  logic                  win_fire,
   input  anem_pkg::window_type  win,
   output logic [anem_pkg::ClickWidth-1:0]   click_count,
   output logic [anem_pkg::SpeedWidth-1:0]   wind_speed,
   output logic [anem_pkg::SpeedWidth-1:0]   gust_speed,
   output logic signed [anem_pkg::DirWidth-1:0] gust_direction,
   output logic signed [anem_pkg::DirWidth-1:0] last_heading
);

   localparam int SW = anem_pkg::SpeedWidth;

   logic [SW-1:0] speed, gust_ff, gust_in;
   logic signed [anem_pkg::DirWidth-1:0] gdir_ff, gdir_in;
   logic [anem_pkg::ClickWidth-1:0] click_ff;
   logic [SW-1:0] speed_ff;
   logic signed [anem_pkg::DirWidth-1:0] wdir_ff;
   logic          is_gust;

   // Scale clicks to speed and latch a new gust on a strict rise
   always_comb begin
      speed   = SW'(win.click_count) * SW'(speed_scale);
      is_gust = speed > gust_ff;
      gust_in = is_gust ? speed : gust_ff;
      gdir_in = is_gust ? win.last_heading : gdir_ff;
   end

   // Gust is cleared only at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         gust_ff <= '0;
         gdir_ff <= anem_pkg::DirUnknown;
      end else if (win_fire) begin
         gust_ff <= gust_in;
         gdir_ff <= gdir_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (win_fire) begin
         click_ff <= win.click_count;
         speed_ff <= speed;
         wdir_ff  <= win.last_heading;
      end
   end

   assign click_count    = click_ff;
   assign wind_speed     = speed_ff;
   assign gust_speed     = gust_ff;
   assign gust_direction = gdir_ff;
   assign last_heading   = wdir_ff;

endmodule

/* hdl/anemometer_speed_gust_direction.sv */
// Channel  | Direction | Payload
// req_     | in        | one time tick: anemometer edge, vane sample (tuser: sample valid)
// rsp_     | out       | window result: clicks, speed, gust, gust and wind direction
// csr_     | in        | register write: debounce, window length, speed scale
//
// One tick item is accepted every cycle while req_tready is high. A tick passes
// an input register, the tick stage (debounce, vane decode, window counter) and
// the gust stage (8x16 multiply, gust compare); a result is valid once its tick
// has passed the window and gust output registers. Reset is synchronous and
// restores the registers, the stage valid flags and the tick and gust state;
// req_tready is low during reset. A stalled result holds in its register; ticks
// still enter until all three stages are full, after which req_tready drops.
module anemometer_speed_gust_direction (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // wind_edge[0], dir_sample[12:1], zero[15:13]
   input  logic         req_tuser,   // dir_valid[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,   // click_count[7:0], wind_speed[31:8],
                                     // gust_speed[55:32], gust_direction[65:56],
                                     // last_heading[75:66], zero[79:76]
   input  logic         csr_wen,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   anem_pkg::cfg_type    cfg_ff;
   anem_pkg::tick_type   tick_ff;
   anem_pkg::window_type win_ff, win_in;
   logic in_v_ff, win_v_ff, out_v_ff;
   logic out_open, win_open, in_open;
   logic tick_fire, win_fire, win_end;

   logic [anem_pkg::ClickWidth-1:0] click_count;
   logic [anem_pkg::SpeedWidth-1:0] wind_speed, gust_speed;
   logic signed [anem_pkg::DirWidth-1:0] gust_direction, last_heading;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= anem_pkg::DebounceReset;
         cfg_ff.window_ticks   <= anem_pkg::WindowReset;
         cfg_ff.speed_scale    <= anem_pkg::ScaleReset;
      end else if (csr_wen) begin
         unique case (csr_addr)
            anem_pkg::RegDebounce: cfg_ff.debounce_ticks <= csr_wdata;
            anem_pkg::RegWindow:   cfg_ff.window_ticks   <= csr_wdata;
            anem_pkg::RegScale:    cfg_ff.speed_scale    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage flow: each stage moves when the next has room
   assign out_open  = !out_v_ff || rsp_tready;
   assign win_open  = !win_v_ff || out_open;
   assign in_open   = !in_v_ff || win_open;
   assign tick_fire = in_v_ff && win_open;
   assign win_fire  = win_v_ff && out_open;
   assign req_tready = in_open && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         win_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (in_open) begin
            in_v_ff <= req_tvalid;
         end
         if (win_open) begin
            win_v_ff <= tick_fire && win_end;
         end
         if (out_open) begin
            out_v_ff <= win_fire;
         end
      end
   end

   // Capture the incoming tick
   always_ff @(posedge clock) begin
      if (in_open && req_tvalid) begin
         tick_ff.wind_edge  <= req_tdata[0];
         tick_ff.dir_valid  <= req_tuser;
         tick_ff.dir_sample <= req_tdata[12:1];
      end
   end

   anem_tick u_tick (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .tick_fire (tick_fire),
      .tick      (tick_ff),
      .win_end   (win_end),
      .win       (win_in)
   );

   // Hold the window summary for the gust stage
   always_ff @(posedge clock) begin
      if (tick_fire && win_end) begin
         win_ff <= win_in;
      end
   end

   anem_gust u_gust (
      .clock          (clock),
      .reset          (reset),
      .speed_scale    (cfg_ff.speed_scale),
      .win_fire       (win_fire),
      .win            (win_ff),
      .click_count    (click_count),
      .wind_speed     (wind_speed),
      .gust_speed     (gust_speed),
      .gust_direction (gust_direction),
      .last_heading   (last_heading)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0, last_heading, gust_direction, gust_speed, wind_speed,
                        click_count};

endmodule
